// ===== hdl/dlfs_pkg.sv =====
// ----------------------------------------------------------------------------
// dlfs_pkg
// Shared types and constants of the dictionary line field splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package dlfs_pkg;

  localparam logic [7:0] WORD_MAX    = 8'd31;
  localparam logic [7:0] MEANING_MAX = 8'd191;

  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_BAR = 8'h7C;
  localparam logic [7:0] BYTE_BSL = 8'h5C;
  localparam logic [7:0] BYTE_N   = 8'h6E;

  localparam logic [1:0] FIELD_WORD     = 2'd0;
  localparam logic [1:0] FIELD_PHONETIC = 2'd1;
  localparam logic [1:0] FIELD_MEANING  = 2'd2;

  // Result queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  typedef struct packed {
    logic [1:0] field_kind;
    logic [7:0] char_pos;
    logic [7:0] char_value;
    logic       entry_end;
    logic       last_item;
  } result_t;

  // Results produced by one accepted byte: n of them, in r0 then r1.
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

// ===== hdl/dlfs_if.sv =====
// ----------------------------------------------------------------------------
// dlfs_byte_if / dlfs_char_if
// Valid/ready channels for input bytes and for split characters.
// ----------------------------------------------------------------------------
`default_nettype none

interface dlfs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface dlfs_char_if;
  logic       valid;
  logic       ready;
  logic [1:0] field_kind;
  logic [7:0] char_pos;
  logic [7:0] char_value;
  logic       entry_end;
  logic       last_item;

  modport source (output valid, output field_kind, output char_pos,
                  output char_value, output entry_end, output last_item,
                  input ready);
  modport sink   (input valid, input field_kind, input char_pos,
                  input char_value, input entry_end, input last_item,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/dlfs_parser.sv =====
// ----------------------------------------------------------------------------
// dlfs_parser
// Field state registers and the per-byte split logic.
// ----------------------------------------------------------------------------
`default_nettype none

module dlfs_parser
  import dlfs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] in_byte,
  output push_t           push
);

  logic [1:0] current_field, current_field_next;
  logic [7:0] fill_count, fill_count_next;
  logic       held_backslash, held_backslash_next;

  logic       is_term;
  logic       pre_valid;
  result_t    pre_res;
  logic       m_run;
  logic [7:0] m_count;
  logic       m_valid;
  result_t    m_res;

  assign is_term = (in_byte == BYTE_NUL) || (in_byte == BYTE_LF);

  always_comb begin
    current_field_next  = current_field;
    fill_count_next     = fill_count;
    held_backslash_next = held_backslash;
    pre_valid           = 1'b0;
    pre_res             = '0;
    m_run               = 1'b0;
    m_count             = fill_count;
    m_valid             = 1'b0;
    m_res               = '0;

    if (!current_field[1]) begin
      if (is_term) begin
        pre_valid           = 1'b1;
        pre_res.entry_end   = 1'b1;
        current_field_next  = FIELD_WORD;
        fill_count_next     = '0;
        held_backslash_next = 1'b0;
      end else if (in_byte == BYTE_BAR) begin
        current_field_next = current_field + 2'd1;
        fill_count_next    = '0;
      end else if (fill_count < WORD_MAX) begin
        pre_valid          = 1'b1;
        pre_res.field_kind = current_field;
        pre_res.char_pos   = fill_count;
        pre_res.char_value = in_byte;
        fill_count_next    = fill_count + 8'd1;
      end else begin
        // Full field: the byte opens the next field as its first character.
        current_field_next = current_field + 2'd1;
        if (current_field == FIELD_WORD) begin
          pre_valid          = 1'b1;
          pre_res.field_kind = FIELD_PHONETIC;
          pre_res.char_pos   = '0;
          pre_res.char_value = in_byte;
          fill_count_next    = 8'd1;
        end else begin
          held_backslash_next = 1'b0;
          m_run               = 1'b1;
          m_count             = '0;
        end
      end
    end else if (held_backslash) begin
      held_backslash_next = 1'b0;
      pre_valid           = 1'b1;
      pre_res.field_kind  = FIELD_MEANING;
      pre_res.char_pos    = fill_count;
      fill_count_next     = fill_count + 8'd1;
      if (in_byte == BYTE_N) begin
        pre_res.char_value = BYTE_LF;
      end else begin
        // The held backslash is kept and this byte is handled on its own.
        pre_res.char_value = BYTE_BSL;
        m_run              = 1'b1;
        m_count            = fill_count + 8'd1;
      end
    end else begin
      m_run = 1'b1;
    end

    if (m_run) begin
      fill_count_next = m_count;
      if (is_term) begin
        m_valid             = 1'b1;
        m_res.entry_end     = 1'b1;
        current_field_next  = FIELD_WORD;
        fill_count_next     = '0;
        held_backslash_next = 1'b0;
      end else if (m_count >= MEANING_MAX) begin
        m_valid = 1'b0;
      end else if (in_byte == BYTE_BSL) begin
        held_backslash_next = 1'b1;
      end else begin
        m_valid          = 1'b1;
        m_res.field_kind = FIELD_MEANING;
        m_res.char_pos   = m_count;
        m_res.char_value = in_byte;
        fill_count_next  = m_count + 8'd1;
      end
    end

    m_res.last_item = 1'b1;
    pre_res.last_item = !m_valid;
    push.n  = {1'b0, pre_valid} + {1'b0, m_valid};
    push.r0 = pre_valid ? pre_res : m_res;
    push.r1 = m_res;
    if (!accept) begin
      push.n = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_field  <= FIELD_WORD;
      fill_count     <= '0;
      held_backslash <= 1'b0;
    end else if (accept) begin
      current_field  <= current_field_next;
      fill_count     <= fill_count_next;
      held_backslash <= held_backslash_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dlfs_queue.sv =====
// ----------------------------------------------------------------------------
// dlfs_queue
// Small result queue: takes up to two results a cycle, gives one a cycle while the output is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module dlfs_queue
  import dlfs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire push_t  push,
  output logic        room,
  output logic        out_valid,
  input  wire logic   out_ready,
  output result_t     out_res
);

  result_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count, count_next;
  logic               pop;
  logic [QPTR_W-1:0]  wr_ptr1;

  assign out_valid = (count != '0);
  assign out_res   = slots[rd_ptr];
  assign pop       = out_valid && out_ready;
  // Room for two more results whatever the output side does.
  assign room      = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign wr_ptr1   = wr_ptr + QPTR_W'(1);

  always_comb begin
    count_next = count + QCNT_W'(push.n) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      slots[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      slots[wr_ptr1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dict_line_field_splitter_top.sv =====
// ----------------------------------------------------------------------------
// dict_line_field_splitter_top
// Splits dictionary line bytes into word, phonetic and meaning characters.
// ----------------------------------------------------------------------------
// Usage:
//   bytes: one line byte per transaction; 0x0A or 0x00 ends the entry.
//   chars: one transaction per kept character, tagged with its field and its
//     position in that field, plus one end-of-entry transaction per line.
//     last_item marks the final transaction caused by an input byte; a byte
//     may cause none, one or two.
//   Output: results are registered in the queue and offered on chars in order.
//   Throughput: one byte per cycle while the queue has room. The splitter
//   state updates in the cycle a byte is taken, and results land in a
//   four-entry queue that drains one transaction per cycle while chars is
//   ready, so the input stalls only while results outpace the output.
//   Stall: if chars is not ready, the queue fills and bytes.ready drops once
//   fewer than two free entries remain; nothing is lost.
//   Reset: rst (synchronous) empties the queue and returns to the start of a
//   word field with no backslash held.
// ----------------------------------------------------------------------------
`default_nettype none

module dict_line_field_splitter_top
  import dlfs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  dlfs_byte_if.sink   bytes,
  dlfs_char_if.source chars
);

  logic    accept;
  logic    room;
  push_t   push;
  result_t head;

  assign bytes.ready = room;
  assign accept      = bytes.valid && room;

  dlfs_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (bytes.in_byte),
    .push    (push)
  );

  dlfs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (chars.valid),
    .out_ready (chars.ready),
    .out_res   (head)
  );

  assign chars.field_kind = head.field_kind;
  assign chars.char_pos   = head.char_pos;
  assign chars.char_value = head.char_value;
  assign chars.entry_end  = head.entry_end;
  assign chars.last_item  = head.last_item;

endmodule

`default_nettype wire
